/* src/svpt_pkg.sv */
// svpt_pkg: widths, constants, shared types and the exponent node table
// for the saturation vapour pressure block. Depends on nothing.
// Every other file of the block uses it by scoped names.
package svpt_pkg;

    // exponent table resolution, a power of two
    localparam int EXP_SEGMENTS = 256;
    localparam int SEG_BITS     = $clog2(EXP_SEGMENTS);
    localparam int FRAC_BITS    = 28 - SEG_BITS;
    localparam int NODE_W       = 32;

    localparam int TEMP_W  = 14;
    localparam int HUM_W   = 10;
    localparam int SAT_W   = 18;
    localparam int SLOPE_W = 20;
    localparam int E_W     = 28;   // e(T) in 0.1 Pa, 8 fraction bits
    localparam int DT_W    = 15;   // T + 237.30 C in 0.01 C

    // exponent divider: 33 quotient bits, 22 bit divisor
    localparam int TET_QB  = 33;
    localparam int TET_DW  = 22;
    localparam int TET_LAT = 3 + TET_QB + 4;

    // slope divider: 20 quotient bits after an overflow test
    localparam int SL_QB     = 20;
    localparam int TERMS_LAT = 3 + SL_QB + 1;
    localparam int LAT_ALL   = TET_LAT + TERMS_LAT;

    localparam int          TETENS_MUL = 1727;
    localparam int          LOG2E_Q28  = 387270501;
    localparam logic [63:0] LN2_Q30    = 64'd744261118;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam int          T_OFFSET   = 23730;
    localparam int          DEN_SCALE  = 100;
    localparam int          SH_BASE    = 38;
    localparam int          ESAT_MUL   = 6108;
    localparam logic [31:0] SLOPE_MUL  = 32'd4098000000;
    localparam int          ACT_HALF   = 256000;
    localparam int          ACT_RECIP  = 34359739;   // ceil(2^32 / 125)
    localparam int          ACT_SAT_X  = 32768000;   // 125 * 2^18
    localparam logic [SAT_W-1:0]   SAT18 = '1;
    localparam logic [SLOPE_W-1:0] SAT20 = '1;

    localparam logic signed [TEMP_W-1:0] LIMIT_LOW_RST  = -14'sd6000;
    localparam logic signed [TEMP_W-1:0] LIMIT_HIGH_RST = 14'sd6000;

    typedef logic [E_W-1:0] t_epress;

    typedef enum logic [0:0] {
        CFG_TEMP_LOW  = 1'b0,
        CFG_TEMP_HIGH = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [SAT_W-1:0]   sat_min;
        logic [SAT_W-1:0]   sat_max;
        logic [SAT_W-1:0]   mean_sat;
        logic [SLOPE_W-1:0] slope;
        logic [SAT_W-1:0]   actual_vp;
    } t_terms;

    typedef logic [EXP_SEGMENTS:0][NODE_W-1:0] t_rom;

    // node k = 2^(k/EXP_SEGMENTS) in Q30 by a truncating Taylor series
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        for (int k = 0; k <= EXP_SEGMENTS; k++) begin
            z    = (64'(k) * LN2_Q30) / 64'(EXP_SEGMENTS);
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int i = 1; i <= 24; i++) begin
                if (term != 64'd0) begin
                    term = ((term * z) >> 30) / 64'(i);
                    sum  = sum + term;
                end
            end
            rom[k] = sum[NODE_W-1:0];
        end
        return rom;
    endfunction

    localparam t_rom NODE_ROM = f_build_rom();

    function automatic logic [SAT_W-1:0] f_sat18(input logic [20:0] v);
        return (v > 21'(SAT18)) ? SAT18 : v[SAT_W-1:0];
    endfunction

endpackage

/* src/svpt_tetens.sv */
// svpt_tetens: pipelined Tetens saturation pressure e(T), 0.1 Pa in Q8.
// Exponent by a one-bit-per-stage divider, then table interpolation of 2^f.
// Depends on svpt_pkg.
module svpt_tetens (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [svpt_pkg::TEMP_W-1:0]  i_temp,
    output svpt_pkg::t_epress                   o_e_q8
);

    logic signed [15:0]               w_tofs;
    logic signed [24:0]               r_p1;
    logic [svpt_pkg::TET_DW-1:0]      r_den1;
    logic [svpt_pkg::TET_DW-1:0]      r_den2;
    logic signed [53:0]               r_num2;
    logic [54:0]                      w_numo;

    logic [svpt_pkg::TET_DW-1:0]      r_rem [0:svpt_pkg::TET_QB];
    logic [svpt_pkg::TET_QB-1:0]      r_wk  [0:svpt_pkg::TET_QB];
    logic [svpt_pkg::TET_DW-1:0]      r_dv  [0:svpt_pkg::TET_QB];
    logic [svpt_pkg::TET_DW-1:0]      n_rem [1:svpt_pkg::TET_QB];
    logic [svpt_pkg::TET_QB-1:0]      n_wk  [1:svpt_pkg::TET_QB];

    logic [svpt_pkg::TET_QB-1:0]      w_yu;
    logic [svpt_pkg::SEG_BITS-1:0]    w_seg;
    logic [svpt_pkg::NODE_W-1:0]      w_a;
    logic [svpt_pkg::NODE_W-1:0]      w_b;

    logic [4:0]                       r_ip1;
    logic [4:0]                       r_ip2;
    logic [svpt_pkg::NODE_W-1:0]      r_a1;
    logic [svpt_pkg::NODE_W-1:0]      r_d1;
    logic [svpt_pkg::FRAC_BITS-1:0]   r_fr1;
    logic [svpt_pkg::NODE_W-1:0]      r_m2;
    logic [44:0]                      r_p3;
    logic [5:0]                       r_sh3;
    logic [45:0]                      w_half;
    logic [45:0]                      w_round;

    assign w_tofs = 16'(i_temp) + 16'(svpt_pkg::T_OFFSET);
    // bias by 16 in the exponent so the dividend is never negative
    assign w_numo = 55'(r_num2) + 55'({r_den2, 32'b0});

    always_comb begin
        logic [svpt_pkg::TET_DW:0] trial;
        for (int s = 0; s < svpt_pkg::TET_QB; s++) begin
            trial = {r_rem[s], r_wk[s][svpt_pkg::TET_QB-1]};
            if (trial >= {1'b0, r_dv[s]}) begin
                n_rem[s+1] = svpt_pkg::TET_DW'(trial - {1'b0, r_dv[s]});
                n_wk[s+1]  = {r_wk[s][svpt_pkg::TET_QB-2:0], 1'b1};
            end else begin
                n_rem[s+1] = trial[svpt_pkg::TET_DW-1:0];
                n_wk[s+1]  = {r_wk[s][svpt_pkg::TET_QB-2:0], 1'b0};
            end
        end
    end

    assign w_yu  = r_wk[svpt_pkg::TET_QB];
    assign w_seg = w_yu[27 -: svpt_pkg::SEG_BITS];
    assign w_a   = svpt_pkg::NODE_ROM[{1'b0, w_seg}];
    assign w_b   = svpt_pkg::NODE_ROM[(svpt_pkg::SEG_BITS+1)'(w_seg) + 1'b1];

    assign w_half  = 46'(1) << (r_sh3 - 6'd1);
    assign w_round = 46'(r_p3) + w_half;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= 25'(i_temp) * 25'(svpt_pkg::TETENS_MUL);
            r_den1 <= svpt_pkg::TET_DW'(unsigned'(w_tofs)) * svpt_pkg::TET_DW'(svpt_pkg::DEN_SCALE);
            r_num2 <= 54'(r_p1) * 54'(svpt_pkg::LOG2E_Q28);
            r_den2 <= r_den1;
            r_rem[0] <= w_numo[54:33];
            r_wk[0]  <= w_numo[32:0];
            r_dv[0]  <= r_den2;
            for (int s = 1; s <= svpt_pkg::TET_QB; s++) begin
                r_rem[s] <= n_rem[s];
                r_wk[s]  <= n_wk[s];
                r_dv[s]  <= r_dv[s-1];
            end
            // interpolate between neighbouring nodes, clamp a falling step
            r_ip1 <= w_yu[32:28];
            r_a1  <= w_a;
            r_d1  <= (w_b > w_a) ? (w_b - w_a) : '0;
            r_fr1 <= w_yu[svpt_pkg::FRAC_BITS-1:0];
            r_m2  <= r_a1 + svpt_pkg::NODE_W'((48'(r_d1) * 48'(r_fr1)) >> svpt_pkg::FRAC_BITS);
            r_ip2 <= r_ip1;
            r_p3  <= 45'(r_m2) * 45'(svpt_pkg::ESAT_MUL);
            r_sh3 <= 6'(svpt_pkg::SH_BASE) - 6'(r_ip2);
            o_e_q8 <= svpt_pkg::E_W'(w_round >> r_sh3);
        end
    end

endmodule

/* src/svpt_terms.sv */
// svpt_terms: derived terms from the three saturation pressures: rounded
// pressures, their mean, the curve slope (pipelined divider) and actual
// vapour pressure. Depends on svpt_pkg.
module svpt_terms (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  svpt_pkg::t_epress                 i_emin,
    input  svpt_pkg::t_epress                 i_emax,
    input  svpt_pkg::t_epress                 i_emean,
    input  logic [svpt_pkg::DT_W-1:0]         i_dt,
    input  logic [svpt_pkg::HUM_W-1:0]        i_hmin,
    input  logic [svpt_pkg::HUM_W-1:0]        i_hmax,
    output svpt_pkg::t_terms                  o_terms
);

    typedef struct packed {
        logic [svpt_pkg::SAT_W-1:0] sat_min;
        logic [svpt_pkg::SAT_W-1:0] sat_max;
        logic [svpt_pkg::SAT_W-1:0] mean_sat;
        logic [svpt_pkg::SAT_W-1:0] actual_vp;
    } t_vp_terms;

    // slope path
    logic [59:0] r_en1;
    logic [29:0] r_sq1;
    logic [29:0] r_sq2;
    logic [60:0] r_num2;
    logic [37:0]                   r_srem [0:svpt_pkg::SL_QB];
    logic [svpt_pkg::SL_QB-1:0]    r_swk  [0:svpt_pkg::SL_QB];
    logic [29:0]                   r_ssq  [0:svpt_pkg::SL_QB];
    logic                          r_ssat [0:svpt_pkg::SL_QB];
    logic [37:0]                   n_srem [1:svpt_pkg::SL_QB];
    logic [svpt_pkg::SL_QB-1:0]    n_swk  [1:svpt_pkg::SL_QB];

    // actual pressure and rounding path
    logic [37:0]        r_pa;
    logic [37:0]        r_pb;
    logic [27:0]        r_x;
    logic               r_xsat;
    logic [50:0]        r_prod;
    svpt_pkg::t_epress  r_ea [1:3];
    svpt_pkg::t_epress  r_eb [1:3];
    t_vp_terms          n_vp;
    t_vp_terms          r_dl [4:svpt_pkg::TERMS_LAT-1];

    always_comb begin
        logic [38:0] trial;
        for (int s = 0; s < svpt_pkg::SL_QB; s++) begin
            trial = {r_srem[s], r_swk[s][svpt_pkg::SL_QB-1]};
            if (trial >= {1'b0, r_ssq[s], 8'b0}) begin
                n_srem[s+1] = 38'(trial - {1'b0, r_ssq[s], 8'b0});
                n_swk[s+1]  = {r_swk[s][svpt_pkg::SL_QB-2:0], 1'b1};
            end else begin
                n_srem[s+1] = trial[37:0];
                n_swk[s+1]  = {r_swk[s][svpt_pkg::SL_QB-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_vp.sat_min   = svpt_pkg::f_sat18(21'((29'(r_ea[3]) + 29'd128) >> 8));
        n_vp.sat_max   = svpt_pkg::f_sat18(21'((29'(r_eb[3]) + 29'd128) >> 8));
        n_vp.mean_sat  = svpt_pkg::f_sat18(21'((30'(r_ea[3]) + 30'(r_eb[3]) + 30'd256) >> 9));
        n_vp.actual_vp = r_xsat ? svpt_pkg::SAT18 : r_prod[49:32];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_en1  <= 60'(i_emean) * 60'(svpt_pkg::SLOPE_MUL);
            r_sq1  <= 30'(i_dt) * 30'(i_dt);
            r_num2 <= 61'(r_en1) + 61'({r_sq1, 7'b0});
            r_sq2  <= r_sq1;
            // quotient of 2^20 or more saturates
            r_ssat[0] <= (r_num2[60:20] >= 41'({r_sq2, 8'b0}));
            r_srem[0] <= r_num2[57:20];
            r_swk[0]  <= r_num2[19:0];
            r_ssq[0]  <= r_sq2;
            for (int s = 1; s <= svpt_pkg::SL_QB; s++) begin
                r_srem[s] <= n_srem[s];
                r_swk[s]  <= n_swk[s];
                r_ssq[s]  <= r_ssq[s-1];
                r_ssat[s] <= r_ssat[s-1];
            end

            r_pa  <= 38'(i_emin) * 38'(i_hmax);
            r_pb  <= 38'(i_emax) * 38'(i_hmin);
            r_ea[1] <= i_emin;
            r_eb[1] <= i_emax;
            // divide by 512000 as a shift by 12 and a reciprocal of 125
            r_x   <= 28'((40'(r_pa) + 40'(r_pb) + 40'(svpt_pkg::ACT_HALF)) >> 12);
            r_xsat <= (r_x >= 28'(svpt_pkg::ACT_SAT_X));
            r_prod <= 51'(r_x[24:0]) * 51'(svpt_pkg::ACT_RECIP);
            for (int s = 2; s <= 3; s++) begin
                r_ea[s] <= r_ea[s-1];
                r_eb[s] <= r_eb[s-1];
            end

            r_dl[4] <= n_vp;
            for (int s = 5; s < svpt_pkg::TERMS_LAT; s++) begin
                r_dl[s] <= r_dl[s-1];
            end

            o_terms.sat_min   <= r_dl[svpt_pkg::TERMS_LAT-1].sat_min;
            o_terms.sat_max   <= r_dl[svpt_pkg::TERMS_LAT-1].sat_max;
            o_terms.mean_sat  <= r_dl[svpt_pkg::TERMS_LAT-1].mean_sat;
            o_terms.actual_vp <= r_dl[svpt_pkg::TERMS_LAT-1].actual_vp;
            o_terms.slope     <= r_ssat[svpt_pkg::SL_QB] ? svpt_pkg::SAT20
                                                        : r_swk[svpt_pkg::SL_QB];
        end
    end

endmodule

/* src/saturation_vapour_pressure_terms.sv */
// Usage of saturation_vapour_pressure_terms
// Input channel (i_valid / o_stall): one daily record per word, taken at a
// clock edge with i_valid high and o_stall low. Output channel (o_valid /
// i_stall): one result word per record, in order, taken when o_valid is
// high and i_stall low. Configuration (i_cfg_valid / o_cfg_ready): index 0
// writes the low temperature limit, index 1 the high one; ready is always
// high, and writes belong to idle periods; the block does not enforce this.
// Throughput: one record per cycle while o_stall is low, set by the fully
// pipelined dividers (one quotient bit per stage). The exponent unit has
// 33 divider stages and the slope unit 20 divider stages.
// When the receiver stalls, one word waits in the output register and one
// in a skid register; o_stall then rises and the whole pipeline holds.
// Synchronous active-low reset empties the pipeline and both output
// registers and loads the limits with -60.00 C and +60.00 C.
// Depends on svpt_pkg, svpt_tetens and svpt_terms.
module saturation_vapour_pressure_terms (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [svpt_pkg::TEMP_W-1:0]  i_min_temp,
    input  logic signed [svpt_pkg::TEMP_W-1:0]  i_max_temp,
    input  logic signed [svpt_pkg::TEMP_W-1:0]  i_mean_temp,
    input  logic [svpt_pkg::HUM_W-1:0]          i_min_humidity,
    input  logic [svpt_pkg::HUM_W-1:0]          i_max_humidity,
    input  logic                                i_temp_ready,
    input  logic                                i_humidity_ready,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [svpt_pkg::SAT_W-1:0]          o_sat_at_tmin,
    output logic [svpt_pkg::SAT_W-1:0]          o_sat_at_tmax,
    output logic [svpt_pkg::SAT_W-1:0]          o_mean_sat,
    output logic [svpt_pkg::SLOPE_W-1:0]        o_slope,
    output logic [svpt_pkg::SAT_W-1:0]          o_actual_vp,
    output logic                                o_mean_sat_ok,
    output logic                                o_slope_ok,
    output logic                                o_actual_ok,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [0:0]                          i_cfg_index,
    input  logic signed [svpt_pkg::TEMP_W-1:0]  i_cfg_data
);

    typedef struct packed {
        logic mean_ok;
        logic slope_ok;
        logic act_ok;
    } t_flags;

    typedef struct packed {
        logic [svpt_pkg::HUM_W-1:0] hmin;
        logic [svpt_pkg::HUM_W-1:0] hmax;
        logic [svpt_pkg::DT_W-1:0]  dt;
    } t_hum_side;

    typedef struct packed {
        svpt_pkg::t_terms terms;
        t_flags           flags;
    } t_result;

    logic signed [svpt_pkg::TEMP_W-1:0] r_low;
    logic signed [svpt_pkg::TEMP_W-1:0] r_high;

    logic                         w_en;
    logic                         w_accept;
    logic                         w_push;
    logic                         w_take;
    logic                         w_min_in;
    logic                         w_max_in;
    logic                         w_mean_in;
    logic signed [15:0]           w_dt;
    t_flags                       w_flags;
    t_hum_side                    w_side;
    t_result                      w_res;

    logic [svpt_pkg::LAT_ALL:1]   r_vld;
    t_flags                       r_flg [1:svpt_pkg::LAT_ALL];
    t_hum_side                    r_hum [1:svpt_pkg::TET_LAT];

    svpt_pkg::t_epress            w_emin;
    svpt_pkg::t_epress            w_emax;
    svpt_pkg::t_epress            w_emean;
    svpt_pkg::t_terms             w_terms;

    t_result                      r_out;
    logic                         r_out_valid;
    t_result                      r_skid;
    logic                         r_skid_valid;

    // the pipeline moves only while the skid register is free
    assign w_en        = !r_skid_valid;
    assign o_stall     = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && w_en;

    assign w_min_in  = (i_min_temp >= r_low) && (i_min_temp <= r_high);
    assign w_max_in  = (i_max_temp >= r_low) && (i_max_temp <= r_high);
    assign w_mean_in = (i_mean_temp >= r_low) && (i_mean_temp <= r_high);
    assign w_dt      = 16'(i_mean_temp) + 16'(svpt_pkg::T_OFFSET);

    always_comb begin
        w_flags.mean_ok  = i_temp_ready && w_min_in && w_max_in;
        w_flags.slope_ok = i_temp_ready && w_mean_in;
        w_flags.act_ok   = i_temp_ready && i_humidity_ready;
        w_side.hmin = i_min_humidity;
        w_side.hmax = i_max_humidity;
        w_side.dt   = w_dt[svpt_pkg::DT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= svpt_pkg::LIMIT_LOW_RST;
            r_high <= svpt_pkg::LIMIT_HIGH_RST;
        end else if (i_cfg_valid) begin
            case (svpt_pkg::t_cfg_reg'(i_cfg_index))
                svpt_pkg::CFG_TEMP_LOW:  r_low  <= i_cfg_data;
                svpt_pkg::CFG_TEMP_HIGH: r_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    svpt_tetens u_tet_min (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_temp (i_min_temp),
        .o_e_q8 (w_emin)
    );

    svpt_tetens u_tet_max (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_temp (i_max_temp),
        .o_e_q8 (w_emax)
    );

    svpt_tetens u_tet_mean (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_temp (i_mean_temp),
        .o_e_q8 (w_emean)
    );

    svpt_terms u_terms (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_emin  (w_emin),
        .i_emax  (w_emax),
        .i_emean (w_emean),
        .i_dt    (r_hum[svpt_pkg::TET_LAT].dt),
        .i_hmin  (r_hum[svpt_pkg::TET_LAT].hmin),
        .i_hmax  (r_hum[svpt_pkg::TET_LAT].hmax),
        .o_terms (w_terms)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[svpt_pkg::LAT_ALL-1:1], w_accept};
        end
    end

    // side data travelling beside the arithmetic units
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flg[1] <= w_flags;
            r_hum[1] <= w_side;
            for (int s = 2; s <= svpt_pkg::LAT_ALL; s++) begin
                r_flg[s] <= r_flg[s-1];
            end
            for (int s = 2; s <= svpt_pkg::TET_LAT; s++) begin
                r_hum[s] <= r_hum[s-1];
            end
        end
    end

    // drop rejected terms to zero
    always_comb begin
        w_res.flags           = r_flg[svpt_pkg::LAT_ALL];
        w_res.terms.sat_min   = w_terms.sat_min;
        w_res.terms.sat_max   = w_terms.sat_max;
        w_res.terms.mean_sat  = w_res.flags.mean_ok ? w_terms.mean_sat : '0;
        w_res.terms.slope     = w_res.flags.slope_ok ? w_terms.slope : '0;
        w_res.terms.actual_vp = w_res.flags.act_ok ? w_terms.actual_vp : '0;
    end

    assign w_push = w_en && r_vld[svpt_pkg::LAT_ALL];
    assign w_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_take) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sat_at_tmin = r_out.terms.sat_min;
    assign o_sat_at_tmax = r_out.terms.sat_max;
    assign o_mean_sat    = r_out.terms.mean_sat;
    assign o_slope       = r_out.terms.slope;
    assign o_actual_vp   = r_out.terms.actual_vp;
    assign o_mean_sat_ok = r_out.flags.mean_ok;
    assign o_slope_ok    = r_out.flags.slope_ok;
    assign o_actual_ok   = r_out.flags.act_ok;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held while output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid register filled without a stalled output word");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline advanced while held");

    a_rejected_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_mean_sat_ok) |-> (o_mean_sat == '0))
        else $error("rejected mean pressure not zero");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for saturation_vapour_pressure_terms: drives daily records, predicts
// the FAO56 vapour pressure terms in fixed point and checks every result word.
// Depends on svpt_pkg and the block's RTL.
module testbench;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [svpt_pkg::TEMP_W-1:0] tmin;
        logic signed [svpt_pkg::TEMP_W-1:0] tmax;
        logic signed [svpt_pkg::TEMP_W-1:0] tmean;
        logic [svpt_pkg::HUM_W-1:0]         hmin;
        logic [svpt_pkg::HUM_W-1:0]         hmax;
        logic                               tready;
        logic                               hready;
    } t_record;

    typedef struct packed {
        logic [svpt_pkg::SAT_W-1:0]   sat_min;
        logic [svpt_pkg::SAT_W-1:0]   sat_max;
        logic [svpt_pkg::SAT_W-1:0]   mean_sat;
        logic [svpt_pkg::SLOPE_W-1:0] slope;
        logic [svpt_pkg::SAT_W-1:0]   actual_vp;
        logic                         mean_ok;
        logic                         slope_ok;
        logic                         act_ok;
    } t_vp_terms;

    typedef struct {
        t_record   rec;
        logic      known;
        t_vp_terms res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [svpt_pkg::TEMP_W-1:0] i_min_temp = '0, i_max_temp = '0, i_mean_temp = '0;
    logic [svpt_pkg::HUM_W-1:0] i_min_humidity = '0, i_max_humidity = '0;
    logic i_temp_ready = 1'b0, i_humidity_ready = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [svpt_pkg::SAT_W-1:0] o_sat_at_tmin, o_sat_at_tmax, o_mean_sat, o_actual_vp;
    logic [svpt_pkg::SLOPE_W-1:0] o_slope;
    logic o_mean_sat_ok, o_slope_ok, o_actual_ok;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [0:0] i_cfg_index = '0;
    logic signed [svpt_pkg::TEMP_W-1:0] i_cfg_data = '0;

    saturation_vapour_pressure_terms dut (.*);

    always #5 i_clk = ~i_clk;

    t_vp_terms pending_terms[$];
    int  n_errors = 0;
    int  n_checked = 0;
    int  n_sent = 0;
    int  cycle_count = 0;
    logic signed [svpt_pkg::TEMP_W-1:0] lim_low = svpt_pkg::LIMIT_LOW_RST;
    logic signed [svpt_pkg::TEMP_W-1:0] lim_high = svpt_pkg::LIMIT_HIGH_RST;
    int  sink_idle_pct = 22;
    int  hold_cycles = 0;
    logic [63:0] pow_nodes[svpt_pkg::EXP_SEGMENTS+1];

    initial begin
        logic [63:0] z, term, sum;
        for (int k = 0; k <= svpt_pkg::EXP_SEGMENTS; k++) begin
            z = (64'(k) * 64'd744261118) / 64'(svpt_pkg::EXP_SEGMENTS);
            term = 64'd1 << 30;
            sum = term;
            for (int i = 1; i <= 24 && term != 0; i++) begin
                term = ((term * z) >> 30) / 64'(i);
                sum += term;
            end
            pow_nodes[k] = sum;
        end
    end

    // e(T) in 0.1 Pa, Q8
    function automatic logic [63:0] tetens_q8(int t);
        longint num, den, y, yu;
        logic [63:0] frac, pos, seg, rem, a, b, m, p;
        int ip, sh;
        num = longint'(1727 * t) * 64'sd387270501;
        den = 100 * longint'(t + 23730);
        y = num / den;
        if ((num % den) != 0 && num < 0) y -= 1;
        yu = y + (longint'(16) << 28);
        ip = int'(yu >>> 28) - 16;
        frac = yu & 64'hFFFFFFF;
        pos = frac * svpt_pkg::EXP_SEGMENTS;
        seg = pos >> 28;
        rem = pos & 64'hFFFFFFF;
        a = pow_nodes[seg];
        b = pow_nodes[seg + 1];
        m = a + ((((b > a) ? (b - a) : 64'd0) * rem) >> 28);
        p = 64'd6108 * m;
        sh = 22 - ip;
        if (sh < 1) sh = 1;
        if (sh > 62) sh = 62;
        return (p + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [63:0] clip(logic [63:0] v, logic [63:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic t_vp_terms vapour_terms(t_record r);
        t_vp_terms o;
        logic [63:0] emin, emax, em, dt, dv, nm;
        logic in_min, in_max, in_mean;
        emin = tetens_q8(int'(r.tmin));
        emax = tetens_q8(int'(r.tmax));
        in_min = r.tmin >= lim_low && r.tmin <= lim_high;
        in_max = r.tmax >= lim_low && r.tmax <= lim_high;
        in_mean = r.tmean >= lim_low && r.tmean <= lim_high;
        o = '0;
        o.sat_min = svpt_pkg::SAT_W'(clip((emin + 128) >> 8, 262143));
        o.sat_max = svpt_pkg::SAT_W'(clip((emax + 128) >> 8, 262143));
        o.mean_ok = r.tready && in_min && in_max;
        o.slope_ok = r.tready && in_mean;
        o.act_ok = r.tready && r.hready;
        if (o.mean_ok) o.mean_sat = svpt_pkg::SAT_W'(clip((emin + emax + 256) >> 9, 262143));
        if (o.slope_ok) begin
            em = tetens_q8(int'(r.tmean));
            dt = 64'(int'(r.tmean) + 23730);
            dv = 256 * dt * dt;
            nm = em * 64'd4098 * 64'd1000000;
            o.slope = svpt_pkg::SLOPE_W'(clip((nm + dv / 2) / dv, 1048575));
        end
        if (o.act_ok) begin
            nm = emin * r.hmax + emax * r.hmin;
            o.actual_vp = svpt_pkg::SAT_W'(clip((nm + 256000) / 512000, 262143));
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at word %0d: %s got %0d expected %0d", n_checked, what, got, want);
        n_errors++;
    endtask

    // output side: stall at random or hold off for a counted stretch
    always @(posedge i_clk) begin
        t_vp_terms w;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_terms.size() == 0) begin
                report_mismatch("word with no record outstanding", 1, 0);
            end else begin
                w = pending_terms.pop_front();
                if (o_sat_at_tmin != w.sat_min)
                    report_mismatch("sat_at_tmin", o_sat_at_tmin, w.sat_min);
                if (o_sat_at_tmax != w.sat_max)
                    report_mismatch("sat_at_tmax", o_sat_at_tmax, w.sat_max);
                if (o_mean_sat != w.mean_sat)
                    report_mismatch("mean_sat", o_mean_sat, w.mean_sat);
                if (o_slope != w.slope)
                    report_mismatch("slope", o_slope, w.slope);
                if (o_actual_vp != w.actual_vp)
                    report_mismatch("actual_vp", o_actual_vp, w.actual_vp);
                if (o_mean_sat_ok != w.mean_ok)
                    report_mismatch("mean_sat_ok", o_mean_sat_ok, w.mean_ok);
                if (o_slope_ok != w.slope_ok)
                    report_mismatch("slope_ok", o_slope_ok, w.slope_ok);
                if (o_actual_ok != w.act_ok)
                    report_mismatch("actual_ok", o_actual_ok, w.act_ok);
                n_checked++;
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_limit(svpt_pkg::t_cfg_reg idx,
                               logic signed [svpt_pkg::TEMP_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == svpt_pkg::CFG_TEMP_LOW) lim_low = val; else lim_high = val;
    endtask

    task automatic drain();
        while (pending_terms.size() != 0) @(posedge i_clk);
        repeat (svpt_pkg::LAT_ALL + 8) @(posedge i_clk);
    endtask

    // offer one record, idling beforehand at the given rate, hold until taken
    task automatic send_record(t_record r, int idle_pct, bit use_exp = 1'b0,
                               t_vp_terms exp_terms = '0);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_min_temp, i_max_temp, i_mean_temp, i_min_humidity, i_max_humidity,
         i_temp_ready, i_humidity_ready} <= r;
        do @(posedge i_clk); while (o_stall);
        if (use_exp) pending_terms.push_back(exp_terms);
        else pending_terms.push_back(vapour_terms(r));
        n_sent++;
    endtask

    function automatic t_record random_record();
        t_record r;
        logic [63:0] raw;
        int mode;
        mode = $urandom_range(9);
        if (mode == 0) begin
            raw = {$urandom, $urandom};
            r = raw[$bits(t_record)-1:0];
        end else begin
            r.tmin = svpt_pkg::TEMP_W'(int'($urandom_range(12000)) - 6000);
            r.tmax = svpt_pkg::TEMP_W'(int'($urandom_range(12000)) - 6000);
            r.tmean = svpt_pkg::TEMP_W'(int'($urandom_range(12000)) - 6000);
            r.hmin = (mode == 1) ? svpt_pkg::HUM_W'($urandom)
                                 : svpt_pkg::HUM_W'($urandom_range(1000));
            r.hmax = (mode == 1) ? svpt_pkg::HUM_W'($urandom)
                                 : svpt_pkg::HUM_W'($urandom_range(1000));
            r.tready = ($urandom_range(9) != 0);
            r.hready = ($urandom_range(9) != 0);
        end
        return r;
    endfunction

    t_row rows[$];

    initial begin
        int lows[4] = '{-6000, -8192, 0, 6000};
        int highs[4] = '{6000, 8191, 2500, -6000};
        // at 0 C everything is at the bottom of a table segment
        rows.push_back('{'{14'sd0, 14'sd0, 14'sd0, 10'd1000, 10'd1000, 1'b1, 1'b1}, 1'b0, '0});
        rows.push_back('{'{-14'sd6000, 14'sd6000, 14'sd2000, 10'd0, 10'd1000, 1'b1, 1'b1},
                        1'b0, '0});
        rows.push_back('{'{-14'sd8192, 14'sd8191, -14'sd8192, 10'd1023, 10'd1023, 1'b1, 1'b1},
                        1'b0, '0});
        rows.push_back('{'{14'sd8191, 14'sd8191, 14'sd8191, 10'd1023, 10'd1023, 1'b1, 1'b1},
                        1'b0, '0});
        // temperatures not ready: e(0 C) = 610.8 Pa is still given, the rest drops
        rows.push_back('{'{14'sd0, 14'sd0, 14'sd0, 10'd400, 10'd800, 1'b0, 1'b1},
                        1'b1, '{sat_min: 6108, sat_max: 6108, default: 0}});
        rows.push_back('{'{14'sd1000, 14'sd3000, 14'sd2000, 10'd400, 10'd800, 1'b1, 1'b0},
                        1'b0, '0});
        rows.push_back('{'{-14'sd6001, 14'sd100, 14'sd6001, 10'd500, 10'd500, 1'b1, 1'b1},
                        1'b0, '0});
        rows.push_back('{'{14'sd2500, 14'sd3500, -14'sd1, 10'd1, 10'd999, 1'b1, 1'b1},
                        1'b0, '0});
        rows.push_back('{'{-14'sd1, 14'sd1, 14'sd6000, 10'd512, 10'd511, 1'b0, 1'b0},
                        1'b0, '0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; a typed-in row is checked against its own expectation
        foreach (rows[i]) begin
            send_record(rows[i].rec, 0, rows[i].known, rows[i].res);
        end
        i_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_limit(svpt_pkg::CFG_TEMP_LOW, svpt_pkg::TEMP_W'(lows[ph]));
            write_limit(svpt_pkg::CFG_TEMP_HIGH, svpt_pkg::TEMP_W'(highs[ph]));
            for (int n = 0; n < 380; n++) begin
                if (ph == 1 && n == 100) begin
                    // long receiver hold-off so the pipeline fills and stalls
                    hold_cycles <= 300;
                end
                if (ph == 1 && n == 200) begin
                    i_valid <= 1'b0;
                    while (pending_terms.size() != 0) @(posedge i_clk);
                end
                sink_idle_pct <= (ph == 2) ? 0 : 22;
                send_record(random_record(), (ph == 2) ? 0 : 22);
            end
            i_valid <= 1'b0;
            drain();
        end

        $display("%0d records sent, %0d result words checked over 5 limit settings",
                 n_sent, n_checked);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
